[rtl/bcc_pkg.sv]
// Shared types, widths and node tables for the barycentric cluster charge engine.
package bcc_pkg;

    localparam int MAX_ORDER_DEF   = 3;
    localparam int MAX_SOURCES_DEF = 1024;
    localparam int COORD_BITS_DEF  = 32;

    localparam int Q_W       = 32;  // charge
    localparam int L_W       = 32;  // basis value, Q1.30 signed
    localparam int R_W       = 50;  // w/c, signed, magnitude up to 2^48
    localparam int S_W       = 52;  // sum of up to four r values
    localparam int DVD_W     = 79;  // divider dividend
    localparam int DVS_W     = 51;  // divider divisor
    localparam int DIV_CNT_W = 7;
    localparam int ACC_W     = 48;  // point charge accumulator
    localparam int CON_W     = 35;  // one signed contribution
    localparam int PADDR_W   = 22;
    localparam int CLUS_W    = 16;
    localparam int MARK_W    = 3;
    localparam int MARKS_W   = 9;
    localparam int CFG_IDX_W = 4;

    localparam logic signed [L_W-1:0] L_ONE = 32'sh4000_0000;
    localparam logic [L_W-2:0]        L_CAP = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORDER   = 4'd0,
        CFG_X_LOW   = 4'd1,
        CFG_X_HIGH  = 4'd2,
        CFG_Y_LOW   = 4'd3,
        CFG_Y_HIGH  = 4'd4,
        CFG_Z_LOW   = 4'd5,
        CFG_Z_HIGH  = 4'd6,
        CFG_CLUSTER = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic                  valid;
        logic                  first;
        logic signed [L_W-1:0] lx;
        logic signed [L_W-1:0] ly;
        logic signed [L_W-1:0] lz;
        logic signed [Q_W-1:0] q;
    } t_contrib;

    // node position in quarters of the box span, for degree n and node j
    function automatic logic [2:0] node_frac(input logic [1:0] n, input logic [1:0] j);
        logic [2:0] f;
        f = 3'd0;
        unique case (n)
            2'd1: f = (j == 2'd0) ? 3'd4 : 3'd0;
            2'd2: begin
                case (j)
                    2'd0:    f = 3'd4;
                    2'd1:    f = 3'd2;
                    default: f = 3'd0;
                endcase
            end
            2'd3: begin
                case (j)
                    2'd0:    f = 3'd4;
                    2'd1:    f = 3'd3;
                    2'd2:    f = 3'd1;
                    default: f = 3'd0;
                endcase
            end
            default: f = 3'd0;
        endcase
        return f;
    endfunction

endpackage

[rtl/barycentric_cluster_charges_core.sv]
// Top level: config registers, node table, source load and emission sequencer.
//
//  channel  | direction | words carried
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | one source point; tlast marks the final source
//  m_axis   | out       | one interpolation point; tlast final point, tuser drop
//  cfg      | in        | register index and write data, ready always high
//
// Sources are loaded one after another in the load state. After the final
// source, each stored source costs, per axis not on a node, up to 2(n+1) passes
// of the shared divider, then an accumulator walk over the (n+1)^3 points plus
// a pipeline drain. Emission then steps through the read, load and output states
// for each point. Reset is synchronous; the stores need no clearing pass. Input
// stalls for the whole of computation and emission; output stalls hold the point.
module barycentric_cluster_charges_core #(
    parameter int MAX_ORDER   = bcc_pkg::MAX_ORDER_DEF,
    parameter int MAX_SOURCES = bcc_pkg::MAX_SOURCES_DEF,
    parameter int COORD_BITS  = bcc_pkg::COORD_BITS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         s_axis_tvalid,
    output logic                                         s_axis_tready,
    // src_x, src_y, src_z, src_charge, zero pad
    input  logic [((3*COORD_BITS+32+7)/8)*8-1:0]         s_axis_tdata,
    input  logic                                         s_axis_tlast,
    output logic                                         m_axis_tvalid,
    input  logic                                         m_axis_tready,
    // point_address, node_x, node_y, node_z, point_charge, zero pad
    output logic [((22+3*COORD_BITS+32+7)/8)*8-1:0]      m_axis_tdata,
    output logic                                         m_axis_tlast,
    // overflowed
    output logic                                         m_axis_tuser,
    input  logic                                         i_cfg_valid,
    output logic                                         o_cfg_ready,
    input  logic [bcc_pkg::CFG_IDX_W-1:0]                i_cfg_index,
    input  logic [COORD_BITS-1:0]                        i_cfg_data
);
    import bcc_pkg::*;

    localparam int CW    = COORD_BITS;
    localparam int NP    = MAX_ORDER + 1;
    localparam int PTS   = NP * NP * NP;
    localparam int PW    = $clog2(PTS);
    localparam int PCW   = $clog2(PTS + 1);
    localparam int KW    = $clog2(NP);
    localparam int AW    = $clog2(MAX_SOURCES);
    localparam int SCW   = $clog2(MAX_SOURCES + 1);
    localparam int OUT_W = ((22 + 3*COORD_BITS + 32 + 7) / 8) * 8;
    localparam int MEM_W = 3*CW + Q_W + MARKS_W;

    typedef enum logic [12:0] {
        ST_LOAD   = 13'b0000000000001,
        ST_RD     = 13'b0000000000010,
        ST_AXIS   = 13'b0000000000100,
        ST_RSTART = 13'b0000000001000,
        ST_RWAIT  = 13'b0000000010000,
        ST_LCHK   = 13'b0000000100000,
        ST_LWAIT  = 13'b0000001000000,
        ST_WALKW  = 13'b0000010000000,
        ST_WALK   = 13'b0000100000000,
        ST_EDRAIN = 13'b0001000000000,
        ST_ERD    = 13'b0010000000000,
        ST_ELOAD  = 13'b0100000000000,
        ST_EOUT   = 13'b1000000000000
    } t_state;

    t_state r_state;

    // configuration
    logic [1:0]           r_order;
    logic signed [CW-1:0] r_lo [0:2];
    logic signed [CW-1:0] r_hi [0:2];
    logic [CLUS_W-1:0]    r_cluster;

    // sequencer
    logic [SCW-1:0]         r_count;
    logic                   r_drop;
    logic [SCW-1:0]         r_src;
    logic [1:0]             r_axis;
    logic [KW-1:0]          r_kk;
    logic [KW-1:0]          r_k1, r_k2, r_k3;
    logic [PW-1:0]          r_pt;
    logic signed [S_W-1:0]  r_sum;
    logic signed [R_W-1:0]  r_r [0:MAX_ORDER];
    logic signed [L_W-1:0]  r_l [0:2][0:MAX_ORDER];
    logic [PADDR_W-1:0]     r_base;
    logic [OUT_W-1:0]       r_out_data;
    logic                   r_out_last;
    logic                   r_out_user;

    logic [1:0]           ord;
    logic [2:0]           np_eff;
    logic [PCW-1:0]       ppc;
    logic signed [CW-1:0] node [0:2][0:MAX_ORDER];

    logic signed [CW-1:0]  in_c [0:2];
    logic signed [Q_W-1:0] in_q;
    logic [MARKS_W-1:0]    in_marks;
    logic                  in_accept;

    logic [MEM_W-1:0]      rd_word;
    logic signed [CW-1:0]  rd_c [0:2];
    logic signed [Q_W-1:0] rd_q;
    logic [MARKS_W-1:0]    rd_marks;

    logic signed [CW-1:0]  cur_s;
    logic signed [CW-1:0]  cur_node;
    logic [MARK_W-1:0]     cur_mark;
    logic signed [CW:0]    c_diff;
    logic [CW:0]           abs_c;
    logic                  c_neg;
    logic                  is_end;
    logic                  kk_last;
    logic signed [R_W-1:0] rmag;
    logic signed [R_W-1:0] r_new;
    logic signed [R_W-1:0] cur_r;
    logic [R_W-2:0]        abs_rk;
    logic [S_W-2:0]        abs_sum;
    logic                  l_neg;
    logic                  l_sat;
    logic signed [L_W-1:0] l_new;
    logic signed [L_W-1:0] l_capped;

    logic               div_start;
    logic [DVD_W-1:0]   div_a;
    logic [DVS_W-1:0]   div_b;
    logic               div_done;
    logic [DVD_W-1:0]   div_q;

    t_contrib                contrib;
    logic                    acc_busy;
    logic signed [ACC_W-1:0] acc_rd;
    logic signed [Q_W-1:0]   sat_charge;
    logic                    walk_last;

    // effective degree and point count
    always_comb begin
        if (r_order == 2'd0) begin
            ord = 2'd1;
        end else if (32'(r_order) > MAX_ORDER) begin
            ord = 2'(MAX_ORDER);
        end else begin
            ord = r_order;
        end
        np_eff = {1'b0, ord} + 3'd1;
        ppc    = PCW'({4'd0, np_eff} * {4'd0, np_eff} * {4'd0, np_eff});
    end

    // node table: low + floor(span * m / 4)
    always_comb begin
        logic signed [CW:0]   span;
        logic signed [CW+3:0] prod;
        logic signed [CW+3:0] sum;
        for (int a = 0; a < 3; a++) begin
            for (int j = 0; j <= MAX_ORDER; j++) begin
                span = (CW+1)'(r_hi[a]) - (CW+1)'(r_lo[a]);
                prod = (CW+4)'(span) * (CW+4)'($signed({1'b0, node_frac(ord, 2'(j))}));
                sum  = (CW+4)'(r_lo[a]) + (prod >>> 2);
                node[a][j] = sum[CW-1:0];
            end
        end
    end

    // input unpacking and node marks, highest matching node wins
    always_comb begin
        logic [MARK_W-1:0] mk;
        for (int a = 0; a < 3; a++) begin
            in_c[a] = s_axis_tdata[a*CW +: CW];
        end
        in_q     = s_axis_tdata[3*CW +: Q_W];
        in_marks = '0;
        for (int a = 0; a < 3; a++) begin
            mk = '0;
            for (int j = 0; j <= MAX_ORDER; j++) begin
                if ((2'(j) <= ord) && (in_c[a] == node[a][j])) begin
                    mk = {1'b1, 2'(j)};
                end
            end
            in_marks[a*MARK_W +: MARK_W] = mk;
        end
    end

    assign s_axis_tready = (r_state == ST_LOAD);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    bcc_src_mem #(
        .DEPTH (MAX_SOURCES),
        .WIDTH (MEM_W)
    ) u_src_mem (
        .i_clk   (i_clk),
        .i_we    (in_accept && (r_count < SCW'(MAX_SOURCES))),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({in_marks, in_q, in_c[2], in_c[1], in_c[0]}),
        .i_re    (r_state == ST_RD),
        .i_raddr (r_src[AW-1:0]),
        .o_rdata (rd_word)
    );

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            rd_c[a] = rd_word[a*CW +: CW];
        end
        rd_q     = rd_word[3*CW +: Q_W];
        rd_marks = rd_word[3*CW+Q_W +: MARKS_W];
    end

    // per-axis operands of the current divide
    always_comb begin
        case (r_axis)
            2'd0: begin
                cur_s    = rd_c[0];
                cur_node = node[0][r_kk];
                cur_mark = rd_marks[0 +: MARK_W];
            end
            2'd1: begin
                cur_s    = rd_c[1];
                cur_node = node[1][r_kk];
                cur_mark = rd_marks[MARK_W +: MARK_W];
            end
            default: begin
                cur_s    = rd_c[2];
                cur_node = node[2][r_kk];
                cur_mark = rd_marks[2*MARK_W +: MARK_W];
            end
        endcase
        c_diff  = (CW+1)'(cur_s) - (CW+1)'(cur_node);
        c_neg   = c_diff[CW];
        // a zero difference on an unmarked axis counts as one LSB
        abs_c   = (c_diff == '0) ? (CW+1)'(1) : (c_neg ? (CW+1)'(-c_diff) : c_diff);
        kk_last = (2'(r_kk) == ord);
        is_end  = (r_kk == '0) || kk_last;
        rmag    = {1'b0, div_q[R_W-2:0]};
        r_new   = (r_kk[0] ^ c_neg) ? -rmag : rmag;

        cur_r   = r_r[r_kk];
        abs_rk  = cur_r[R_W-1] ? (R_W-1)'(-cur_r) : cur_r[R_W-2:0];
        abs_sum = r_sum[S_W-1] ? (S_W-1)'(-r_sum) : r_sum[S_W-2:0];
        l_neg   = cur_r[R_W-1] ^ r_sum[S_W-1];
        l_sat   = {3'b0, abs_rk} >= {abs_sum, 1'b0};
        l_new   = l_neg ? -$signed({1'b0, div_q[30:0]}) : $signed({1'b0, div_q[30:0]});
        l_capped = l_neg ? -$signed({1'b0, L_CAP}) : $signed({1'b0, L_CAP});

        if (r_state == ST_RSTART) begin
            div_a = is_end ? (DVD_W'(1) << 47) : (DVD_W'(1) << 48);
            div_b = DVS_W'(abs_c);
        end else begin
            div_a = {abs_rk, 30'd0};
            div_b = abs_sum;
        end
        div_start = (r_state == ST_RSTART)
                 || ((r_state == ST_LCHK) && (r_sum != '0) && !l_sat);
    end

    bcc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        contrib.valid = (r_state == ST_WALK);
        contrib.first = (r_src == '0);
        contrib.lx    = r_l[0][r_k1];
        contrib.ly    = r_l[1][r_k2];
        contrib.lz    = r_l[2][r_k3];
        contrib.q     = rd_q;
        walk_last     = ({1'b0, r_pt} == (ppc - PCW'(1)));
    end

    bcc_accum #(
        .PTS (PTS)
    ) u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (contrib),
        .i_pt      (r_pt),
        .i_rd      (r_state == ST_ERD),
        .i_rd_addr (r_pt),
        .o_rd_data (acc_rd),
        .o_busy    (acc_busy)
    );

    always_comb begin
        if (acc_rd > ACC_W'(32'sh7FFF_FFFF)) begin
            sat_charge = 32'sh7FFF_FFFF;
        end else if (acc_rd < -(ACC_W'(33'sh0_8000_0000))) begin
            sat_charge = 32'sh8000_0000;
        end else begin
            sat_charge = acc_rd[Q_W-1:0];
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order   <= 2'd3;
            r_cluster <= '0;
            for (int a = 0; a < 3; a++) begin
                r_lo[a] <= '0;
                r_hi[a] <= CW'(65536);
            end
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ORDER:   r_order   <= i_cfg_data[1:0];
                CFG_X_LOW:   r_lo[0]   <= i_cfg_data;
                CFG_X_HIGH:  r_hi[0]   <= i_cfg_data;
                CFG_Y_LOW:   r_lo[1]   <= i_cfg_data;
                CFG_Y_HIGH:  r_hi[1]   <= i_cfg_data;
                CFG_Z_LOW:   r_lo[2]   <= i_cfg_data;
                CFG_Z_HIGH:  r_hi[2]   <= i_cfg_data;
                CFG_CLUSTER: r_cluster <= i_cfg_data[CLUS_W-1:0];
                default:     ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_drop  <= 1'b0;
            r_src   <= '0;
            r_axis  <= '0;
            r_kk    <= '0;
            r_k1    <= '0;
            r_k2    <= '0;
            r_k3    <= '0;
            r_pt    <= '0;
        end else begin
            unique case (r_state)
                ST_LOAD: begin
                    if (in_accept) begin
                        if (r_count < SCW'(MAX_SOURCES)) begin
                            r_count <= r_count + 1'b1;
                        end else begin
                            r_drop <= 1'b1;
                        end
                        if (s_axis_tlast) begin
                            r_src   <= '0;
                            r_state <= ST_RD;
                        end
                    end
                end
                ST_RD: begin
                    r_axis  <= '0;
                    r_state <= ST_AXIS;
                end
                ST_AXIS: begin
                    r_kk <= '0;
                    if (cur_mark[2]) begin
                        for (int k = 0; k <= MAX_ORDER; k++) begin
                            r_l[r_axis][k] <= (cur_mark[1:0] == 2'(k)) ? L_ONE : '0;
                        end
                        if (r_axis == 2'd2) begin
                            r_state <= ST_WALKW;
                        end else begin
                            r_axis <= r_axis + 2'd1;
                        end
                    end else begin
                        r_sum   <= '0;
                        r_state <= ST_RSTART;
                    end
                end
                ST_RSTART: begin
                    r_state <= ST_RWAIT;
                end
                ST_RWAIT: begin
                    if (div_done) begin
                        r_r[r_kk] <= r_new;
                        r_sum     <= r_sum + S_W'(r_new);
                        if (kk_last) begin
                            r_kk    <= '0;
                            r_state <= ST_LCHK;
                        end else begin
                            r_kk    <= r_kk + 1'b1;
                            r_state <= ST_RSTART;
                        end
                    end
                end
                ST_LCHK: begin
                    if (r_sum == '0) begin
                        for (int k = 0; k <= MAX_ORDER; k++) begin
                            r_l[r_axis][k] <= '0;
                        end
                        r_kk <= '0;
                        if (r_axis == 2'd2) begin
                            r_state <= ST_WALKW;
                        end else begin
                            r_axis  <= r_axis + 2'd1;
                            r_state <= ST_AXIS;
                        end
                    end else if (l_sat) begin
                        r_l[r_axis][r_kk] <= l_capped;
                        if (kk_last) begin
                            r_kk <= '0;
                            if (r_axis == 2'd2) begin
                                r_state <= ST_WALKW;
                            end else begin
                                r_axis  <= r_axis + 2'd1;
                                r_state <= ST_AXIS;
                            end
                        end else begin
                            r_kk <= r_kk + 1'b1;
                        end
                    end else begin
                        r_state <= ST_LWAIT;
                    end
                end
                ST_LWAIT: begin
                    if (div_done) begin
                        r_l[r_axis][r_kk] <= l_new;
                        if (kk_last) begin
                            r_kk <= '0;
                            if (r_axis == 2'd2) begin
                                r_state <= ST_WALKW;
                            end else begin
                                r_axis  <= r_axis + 2'd1;
                                r_state <= ST_AXIS;
                            end
                        end else begin
                            r_kk    <= r_kk + 1'b1;
                            r_state <= ST_LCHK;
                        end
                    end
                end
                ST_WALKW: begin
                    // hold until the previous source has left the accumulator
                    r_k1 <= '0;
                    r_k2 <= '0;
                    r_k3 <= '0;
                    r_pt <= '0;
                    if (!acc_busy) begin
                        r_state <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    r_pt <= r_pt + 1'b1;
                    if (2'(r_k1) == ord) begin
                        r_k1 <= '0;
                        if (2'(r_k2) == ord) begin
                            r_k2 <= '0;
                            r_k3 <= r_k3 + 1'b1;
                        end else begin
                            r_k2 <= r_k2 + 1'b1;
                        end
                    end else begin
                        r_k1 <= r_k1 + 1'b1;
                    end
                    if (walk_last) begin
                        r_src <= r_src + 1'b1;
                        if ((r_src + 1'b1) == r_count) begin
                            r_state <= ST_EDRAIN;
                        end else begin
                            r_state <= ST_RD;
                        end
                    end
                end
                ST_EDRAIN: begin
                    r_k1 <= '0;
                    r_k2 <= '0;
                    r_k3 <= '0;
                    r_pt <= '0;
                    if (!acc_busy) begin
                        r_state <= ST_ERD;
                    end
                end
                ST_ERD: begin
                    r_state <= ST_ELOAD;
                end
                ST_ELOAD: begin
                    r_state <= ST_EOUT;
                end
                ST_EOUT: begin
                    if (m_axis_tready) begin
                        if (r_out_last) begin
                            r_count <= '0;
                            r_drop  <= 1'b0;
                            r_state <= ST_LOAD;
                        end else begin
                            r_pt <= r_pt + 1'b1;
                            if (2'(r_k1) == ord) begin
                                r_k1 <= '0;
                                if (2'(r_k2) == ord) begin
                                    r_k2 <= '0;
                                    r_k3 <= r_k3 + 1'b1;
                                end else begin
                                    r_k2 <= r_k2 + 1'b1;
                                end
                            end else begin
                                r_k1 <= r_k1 + 1'b1;
                            end
                            r_state <= ST_ERD;
                        end
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    // base address and output word
    always_ff @(posedge i_clk) begin
        if (in_accept && s_axis_tlast) begin
            r_base <= PADDR_W'(r_cluster) * PADDR_W'(ppc);
        end
        if (r_state == ST_ELOAD) begin
            r_out_data <= OUT_W'({sat_charge, node[2][r_k3], node[1][r_k2], node[0][r_k1],
                                  PADDR_W'(r_base + PADDR_W'(r_pt))});
            r_out_last <= walk_last;
            r_out_user <= r_drop;
        end
    end

    assign m_axis_tvalid = (r_state == ST_EOUT);
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_user;
endmodule

[rtl/bcc_src_mem.sv]
// Source point store: one write port, one registered read port.
module bcc_src_mem #(
    parameter int DEPTH = bcc_pkg::MAX_SOURCES_DEF,
    parameter int WIDTH = 3 * bcc_pkg::COORD_BITS_DEF + bcc_pkg::Q_W + bcc_pkg::MARKS_W
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/bcc_div.sv]
// Shared radix-2 restoring divider, one quotient bit per cycle.
module bcc_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [bcc_pkg::DVD_W-1:0]  i_dividend,
    input  logic [bcc_pkg::DVS_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [bcc_pkg::DVD_W-1:0]  o_quotient
);
    import bcc_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0]     r_a;
    logic [DVS_W-1:0]     r_b;
    logic [DVS_W:0]       r_rem;
    logic [DVS_W:0]       trial;
    logic [DVS_W:0]       diff;
    logic                 ge;

    always_comb begin
        trial = {r_rem[DVS_W-1:0], r_a[DVD_W-1]};
        ge    = trial >= {1'b0, r_b};
        diff  = trial - {1'b0, r_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out the top while quotient bits shift in below
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_dividend;
            r_b   <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_a   <= {r_a[DVD_W-2:0], ge};
            r_rem <= ge ? diff : trial;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_a;
endmodule

[rtl/bcc_accum.sv]
// Contribution product pipeline and per-point charge accumulator memory.
module bcc_accum #(
    parameter int PTS = (bcc_pkg::MAX_ORDER_DEF + 1) ** 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bcc_pkg::t_contrib               i_in,
    input  logic [$clog2(PTS)-1:0]          i_pt,
    input  logic                            i_rd,
    input  logic [$clog2(PTS)-1:0]          i_rd_addr,
    output logic signed [bcc_pkg::ACC_W-1:0] o_rd_data,
    output logic                            o_busy
);
    import bcc_pkg::*;

    localparam int PW = $clog2(PTS);

    logic signed [ACC_W-1:0] r_mem [0:PTS-1];
    logic signed [ACC_W-1:0] r_rd_data;

    logic          r_v1, r_v2, r_v3, r_v4, r_v5;
    logic          r_f1, r_f2, r_f3, r_f4, r_f5;
    logic [PW-1:0] r_p1, r_p2, r_p3, r_p4, r_p5;
    logic          r_n1, r_n2, r_n3;
    logic [30:0]   r_ax, r_ay, r_az, r_az2;
    logic [31:0]   r_aq1, r_aq2, r_aq3;
    logic [31:0]   r_m1;
    logic [32:0]   r_m2;
    logic signed [CON_W-1:0] r_c4, r_c5;

    logic [61:0] prod1;
    logic [62:0] prod2;
    logic [64:0] prod3;
    logic [CON_W-1:0] cmag;
    logic              rd_en;
    logic [PW-1:0]     rd_addr;

    always_comb begin
        prod1   = 62'(r_ax) * 62'(r_ay);
        prod2   = 63'(r_m1) * 63'(r_az2);
        prod3   = 65'(r_aq3) * 65'(r_m2);
        cmag    = {1'b0, prod3[63:30]};
        rd_en   = r_v4 | i_rd;
        rd_addr = r_v4 ? r_p4 : i_rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        // take magnitudes, carry the sign alongside
        r_f1  <= i_in.first;
        r_p1  <= i_pt;
        r_ax  <= i_in.lx[L_W-1] ? 31'(-i_in.lx) : i_in.lx[30:0];
        r_ay  <= i_in.ly[L_W-1] ? 31'(-i_in.ly) : i_in.ly[30:0];
        r_az  <= i_in.lz[L_W-1] ? 31'(-i_in.lz) : i_in.lz[30:0];
        r_aq1 <= i_in.q[Q_W-1] ? (~i_in.q + 32'd1) : i_in.q;
        r_n1  <= i_in.lx[L_W-1] ^ i_in.ly[L_W-1] ^ i_in.lz[L_W-1] ^ i_in.q[Q_W-1];

        r_f2  <= r_f1;
        r_p2  <= r_p1;
        r_m1  <= prod1[61:30];
        r_az2 <= r_az;
        r_aq2 <= r_aq1;
        r_n2  <= r_n1;

        r_f3  <= r_f2;
        r_p3  <= r_p2;
        r_m2  <= prod2[62:30];
        r_aq3 <= r_aq2;
        r_n3  <= r_n2;

        r_f4  <= r_f3;
        r_p4  <= r_p3;
        r_c4  <= r_n3 ? -$signed(cmag) : $signed(cmag);

        r_f5  <= r_f4;
        r_p5  <= r_p4;
        r_c5  <= r_c4;
    end

    // read-modify-write: read in stage four, add and write back in stage five
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (r_v5) begin
            r_mem[r_p5] <= r_f5 ? ACC_W'(r_c5) : r_rd_data + ACC_W'(r_c5);
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_v1 | r_v2 | r_v3 | r_v4 | r_v5;
endmodule
